/* sv/mfp_pkg.sv */
// shared types and constants for the message fifo with purge
package mfp_pkg;

  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int RES_SLOTS = 3;
  localparam int SLOT_W    = 2;

  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_PURGE = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_ABORT = 3'd4,
    CMD_START = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABORTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PURGE = 1'b1
  } state_t;

  typedef enum logic {
    REG_FLUSH_CODE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] code;
    logic [DATA_W-1:0] first_arg;
    logic [DATA_W-1:0] second_arg;
  } msg_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    cmd_t    kind;
    status_t status;
    msg_t    msg;
    logic    last;
  } res_t;

endpackage

/* sv/mfp_if.sv */
// request and answer channel interfaces
interface mfp_cmd_if import mfp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [2:0]               command;
  logic signed [DATA_W-1:0] msg_code;
  logic signed [DATA_W-1:0] first_arg;
  logic signed [DATA_W-1:0] second_arg;
  logic                     wait_if_empty;

  modport source (output valid, command, msg_code, first_arg, second_arg, wait_if_empty,
                  input ready);
  modport sink (input valid, command, msg_code, first_arg, second_arg, wait_if_empty,
                output ready);
endinterface

interface mfp_ans_if import mfp_pkg::*; #(parameter int QUEUE_DEPTH = 16);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                     valid;
  logic                     ready;
  logic [2:0]               answer_kind;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] out_code;
  logic signed [DATA_W-1:0] out_first_arg;
  logic signed [DATA_W-1:0] out_second_arg;
  logic [CNT_W-1:0]         queued_count;
  logic                     last_of_run;

  modport source (output valid, answer_kind, status, out_code, out_first_arg,
                  out_second_arg, queued_count, last_of_run, input ready);
  modport sink (input valid, answer_kind, status, out_code, out_first_arg,
                out_second_arg, queued_count, last_of_run, output ready);
endinterface

/* sv/mfp_cell.sv */
// one message cell of the queue chain
module mfp_cell import mfp_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  msg_t      load_msg,
  input  msg_t      neighbor_msg,
  output msg_t      msg
);

  // a load wins over the shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      msg <= load_msg;
    end else if (ctl.shift) begin
      msg <= neighbor_msg;
    end
  end

endmodule

/* sv/mfp_res_queue.sv */
// small answer buffer that takes up to two answers a cycle
module mfp_res_queue import mfp_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  res_t             push0,
  input  logic [CNT_W-1:0] push0_cnt,
  input  res_t             push1,
  input  logic [CNT_W-1:0] push1_cnt,
  input  logic             pop,
  output res_t             head,
  output logic [CNT_W-1:0] head_cnt,
  output logic             head_valid,
  output logic             room
);

  res_t             slot      [RES_SLOTS];
  res_t             slot_next [RES_SLOTS];
  logic [CNT_W-1:0] cnt       [RES_SLOTS];
  logic [CNT_W-1:0] cnt_next  [RES_SLOTS];
  logic [SLOT_W-1:0] fill, fill_next, base, base_hi;

  always_comb begin
    base      = fill - {{(SLOT_W-1){1'b0}}, pop};
    base_hi   = base + SLOT_W'(1);
    fill_next = base + push_n;
    for (int i = 0; i < RES_SLOTS; i++) begin
      slot_next[i] = slot[i];
      cnt_next[i]  = cnt[i];
    end
    for (int i = 0; i < RES_SLOTS - 1; i++) begin
      if (pop) begin
        slot_next[i] = slot[i+1];
        cnt_next[i]  = cnt[i+1];
      end
    end
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (push_n != 2'd0 && base == SLOT_W'(i)) begin
        slot_next[i] = push0;
        cnt_next[i]  = push0_cnt;
      end else if (push_n == 2'd2 && base_hi == SLOT_W'(i)) begin
        slot_next[i] = push1;
        cnt_next[i]  = push1_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      slot[i] <= slot_next[i];
      cnt[i]  <= cnt_next[i];
    end
  end

  assign head       = slot[0];
  assign head_cnt   = cnt[0];
  assign head_valid = (fill != '0);
  assign room       = (fill <= SLOT_W'(1));

endmodule

/* sv/message_fifo_with_purge_core.sv */
// top level of the message fifo with selective purge
// answers are registered in the answer buffer; a purge of n > 0 held messages answers when its walk ends
// put, get, flush and abort and start let the next request in at once while the answer buffer has room
// a purge of held messages holds off the next request for the whole chain walk
// reset: synchronous active high; queue empty and aborted, flush_code zero, no clearing pass
// message cells are not cleared; only cells below the count are ever read
module message_fifo_with_purge_core import mfp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  mfp_cmd_if.sink            cmd,
  mfp_ans_if.source          ans,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             aborted, aborted_next;
  logic             pending, pending_next;
  logic [CNT_W-1:0] rem, rem_next;     // purge: messages still to look at
  logic [CNT_W-1:0] len, len_next;     // purge: unvisited plus kept messages
  logic [CNT_W-1:0] len_dec;
  logic [DATA_W-1:0] flush_code;
  logic [DATA_W-1:0] purge_code;

  // cell chain
  msg_t      cell_msg [QUEUE_DEPTH];
  cell_ctl_t cell_ctl [QUEUE_DEPTH];
  logic      shift_all;
  logic      load_en;
  logic [IDX_W-1:0] load_pos;
  msg_t      load_msg;
  msg_t      in_msg;
  msg_t      start_msg;
  logic      head_kept;

  // answers
  logic [1:0]       push_n;
  res_t             push0, push1;
  logic [CNT_W-1:0] push0_cnt, push1_cnt;
  res_t             head;
  logic [CNT_W-1:0] head_cnt;
  logic             head_valid;
  logic             room;
  logic             fire;
  logic             pop;
  cmd_t             cmd_code;

  // config port
  logic     cfg_wr;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    unique case (reg_sel)
      REG_FLUSH_CODE: prdata = flush_code;
      default:        prdata = '0;
    endcase
  end

  // handshakes: take a request only when the answer buffer can hold two more
  assign cmd.ready = (state == S_IDLE) && room;
  assign fire      = cmd.valid && cmd.ready;
  assign pop       = ans.valid && ans.ready;
  assign cmd_code  = cmd_t'(cmd.command);

  assign in_msg.code       = cmd.msg_code;
  assign in_msg.first_arg  = cmd.first_arg;
  assign in_msg.second_arg = cmd.second_arg;

  // start enqueues the flush code with zero arguments
  assign start_msg.code       = flush_code;
  assign start_msg.first_arg  = '0;
  assign start_msg.second_arg = '0;

  assign head_kept = (cell_msg[0].code != purge_code);
  assign len_dec   = len - CNT_W'(1);

  // command decode and purge walk
  always_comb begin
    state_next   = state;
    count_next   = count;
    aborted_next = aborted;
    pending_next = pending;
    rem_next     = rem;
    len_next     = len;
    shift_all    = 1'b0;
    load_en      = 1'b0;
    load_pos     = count[IDX_W-1:0];
    load_msg     = in_msg;
    push_n       = 2'd0;
    push0        = '0;
    push1        = '0;
    push0_cnt    = count;
    push1_cnt    = count;

    unique case (state)
      S_IDLE: begin
        if (fire) begin
          unique case (cmd_code)
            CMD_PUT, CMD_START: begin
              if (cmd_code == CMD_START) begin
                aborted_next = 1'b0;
                load_msg     = start_msg;
              end
              push_n     = 2'd1;
              push0.kind = cmd_code;
              if (aborted && cmd_code == CMD_PUT) begin
                push0.status = ST_ABORTED;
              end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                push0.status = ST_FULL;
              end else begin
                push0.status = ST_OK;
                push0_cnt    = count + CNT_W'(1);
                if (pending) begin
                  // a held get only exists on an empty queue: hand the message straight on
                  pending_next = 1'b0;
                  push_n       = 2'd2;
                  push1.kind   = CMD_GET;
                  push1.status = ST_OK;
                  push1.msg    = load_msg;
                  push1_cnt    = count;
                end else begin
                  load_en    = 1'b1;
                  count_next = count + CNT_W'(1);
                end
              end
            end
            CMD_GET: begin
              if (aborted) begin
                push_n       = 2'd1;
                push0.kind   = CMD_GET;
                push0.status = ST_ABORTED;
              end else if (count != '0) begin
                // deliver the head cell and shift the chain down
                push_n       = 2'd1;
                push0.kind   = CMD_GET;
                push0.status = ST_OK;
                push0.msg    = cell_msg[0];
                push0_cnt    = count - CNT_W'(1);
                shift_all    = 1'b1;
                count_next   = count - CNT_W'(1);
              end else if (cmd.wait_if_empty) begin
                pending_next = 1'b1;
              end else begin
                push_n       = 2'd1;
                push0.kind   = CMD_GET;
                push0.status = ST_EMPTY;
              end
            end
            CMD_PURGE: begin
              if (count == '0) begin
                push_n       = 2'd1;
                push0.kind   = CMD_PURGE;
                push0.status = ST_OK;
              end else begin
                state_next = S_PURGE;
                rem_next   = count;
                len_next   = count;
              end
            end
            CMD_FLUSH: begin
              count_next   = '0;
              push_n       = 2'd1;
              push0.kind   = CMD_FLUSH;
              push0.status = ST_OK;
              push0_cnt    = '0;
            end
            CMD_ABORT: begin
              aborted_next = 1'b1;
              push_n       = 2'd1;
              push0.kind   = CMD_ABORT;
              push0.status = ST_OK;
              if (pending) begin
                pending_next = 1'b0;
                push_n       = 2'd2;
                push1.kind   = CMD_GET;
                push1.status = ST_ABORTED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PURGE: begin
        // pop the head each cycle; a kept message goes back in at the tail
        shift_all = 1'b1;
        load_pos  = len_dec[IDX_W-1:0];
        load_msg  = cell_msg[0];
        load_en   = head_kept;
        len_next  = head_kept ? len : len_dec;
        rem_next  = rem - CNT_W'(1);
        if (rem == CNT_W'(1)) begin
          state_next   = S_IDLE;
          count_next   = len_next;
          push_n       = 2'd1;
          push0.kind   = CMD_PURGE;
          push0.status = ST_OK;
          push0_cnt    = len_next;
        end
      end
      default: begin
      end
    endcase

    push0.last = (push_n == 2'd1);
    push1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      aborted    <= 1'b1;
      pending    <= 1'b0;
      rem        <= '0;
      len        <= '0;
      flush_code <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      aborted <= aborted_next;
      pending <= pending_next;
      rem     <= rem_next;
      len     <= len_next;
      if (cfg_wr && reg_sel == REG_FLUSH_CODE) begin
        flush_code <= pwdata;
      end
    end
  end

  // code to remove, kept for the purge walk
  always_ff @(posedge clk) begin
    if (fire) begin
      purge_code <= cmd.msg_code;
    end
  end

  // the cell chain: cell 0 is always the oldest message
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    msg_t nb_msg;
    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nb_msg = cell_msg[i+1];
    end else begin : g_end
      assign nb_msg = '0;
    end
    assign cell_ctl[i].shift = shift_all;
    assign cell_ctl[i].load  = load_en && (load_pos == IDX_W'(i));
    mfp_cell u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[i]),
      .load_msg     (load_msg),
      .neighbor_msg (nb_msg),
      .msg          (cell_msg[i])
    );
  end

  // answer buffer
  mfp_res_queue #(.CNT_W(CNT_W)) u_res_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push0      (push0),
    .push0_cnt  (push0_cnt),
    .push1      (push1),
    .push1_cnt  (push1_cnt),
    .pop        (pop),
    .head       (head),
    .head_cnt   (head_cnt),
    .head_valid (head_valid),
    .room       (room)
  );

  assign ans.valid          = head_valid;
  assign ans.answer_kind    = head.kind;
  assign ans.status         = head.status;
  assign ans.out_code       = head.msg.code;
  assign ans.out_first_arg  = head.msg.first_arg;
  assign ans.out_second_arg = head.msg.second_arg;
  assign ans.queued_count   = head_cnt;
  assign ans.last_of_run    = head.last;

  // a held get only waits on an empty, running queue
  a_pending_empty: assert property (@(posedge clk) disable iff (rst)
    pending |-> (count == '0))
    else $error("held get with messages in the queue");

  a_pending_not_aborted: assert property (@(posedge clk) disable iff (rst)
    pending |-> !aborted)
    else $error("held get while aborted");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("message count beyond queue depth");

  a_purge_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_PURGE && rem == CNT_W'(1)) |=> (state == S_IDLE && count == $past(len_next)))
    else $error("purge walk did not finish with the kept count");

endmodule
